// ===== sv/combination_rank_unrank_macros.svh =====
// Assertion macros for the combination rank/unrank RTL.
`ifndef COMBINATION_RANK_UNRANK_MACROS_SVH
`define COMBINATION_RANK_UNRANK_MACROS_SVH
`ifndef SYNTHESIS
`define CRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("combination_rank_unrank check failed");
`define CRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("combination_rank_unrank check failed");
`else
`define CRU_ASSERT_IMP(lbl, ante, cons)
`define CRU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/ccr_pkg.sv =====
// Types, codes and sizing helpers for the combination rank/unrank block.
`timescale 1ns / 1ps
package ccr_pkg;

  localparam int WORD_W = 32;
  localparam int REG_W  = 6;

  localparam logic CMD_UNRANK = 1'b0;
  localparam logic CMD_RANK   = 1'b1;

  localparam logic REG_SITE_COUNT    = 1'b0;
  localparam logic REG_SET_BIT_COUNT = 1'b1;

  typedef struct packed {
    logic [REG_W-1:0] site_count;
    logic [REG_W-1:0] set_bit_count;
  } cfg_t;

  // usable site count: the pattern never grows past the result word
  function automatic int site_lim(input int max_sites);
    return (max_sites < WORD_W) ? max_sites : WORD_W;
  endfunction

  // Pascal table holds rows 0..site_lim, each row site_lim+1 entries wide
  function automatic int tab_depth(input int max_sites);
    return (site_lim(max_sites) + 1) * (site_lim(max_sites) + 1);
  endfunction

endpackage

// ===== sv/ccr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ccr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1089,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ccr_seq.sv =====
// Sequencer: Pascal table fill after reset, then rank and unrank walks over the table.
`timescale 1ns / 1ps
`include "combination_rank_unrank_macros.svh"
module ccr_seq import ccr_pkg::*; #(
  parameter int MAX_SITES = 32,
  localparam int AW = $clog2(tab_depth(MAX_SITES))
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              start,
  input  logic              command,
  input  logic [WORD_W-1:0] value,
  output logic              busy,
  output logic              done,
  output logic [WORD_W-1:0] result,
  output logic              error,
  output logic              tab_we,
  output logic [AW-1:0]     tab_waddr,
  output logic [WORD_W-1:0] tab_wdata,
  output logic [AW-1:0]     tab_raddr,
  input  logic [WORD_W-1:0] tab_rdata
);

  localparam int SITE_LIM = site_lim(MAX_SITES);
  localparam int ROW = SITE_LIM + 1;
  localparam logic [REG_W-1:0] LIM_N = REG_W'(SITE_LIM);

  typedef enum logic [2:0] {
    S_FILL_RD,
    S_FILL_WR,
    S_IDLE,
    S_UCHK,
    S_UWALK,
    S_RWALK,
    S_RLAST
  } state_t;

  state_t state, state_next;
  logic [REG_W-1:0]  fn, fn_next, fk, fk_next;
  logic [WORD_W-1:0] held, held_next;
  logic [REG_W-1:0]  p, p_next, i, i_next, cnt, cnt_next;
  logic [WORD_W-1:0] rem, rem_next, pat, pat_next, sum, sum_next;
  logic [WORD_W-1:0] val, val_next;
  logic              cmd, cmd_next, zf, zf_next, pend, pend_next;
  logic              done_next, error_next;
  logic [WORD_W-1:0] result_next;

  logic [WORD_W-1:0] c, lo_mask, bitp, sum_fin;
  logic [REG_W-1:0]  pm1, inx;
  logic              take, cfg_ok, fill_row_end, fill_end;

  // entries with k > n are never written; callers treat them as zero
  function automatic logic [AW-1:0] tab_addr(input logic [REG_W-1:0] n,
                                             input logic [REG_W-1:0] k);
    if (k > n || n > LIM_N) begin
      return '0;
    end
    return AW'(int'(n) * ROW + int'(k));
  endfunction

  assign busy = (state != S_IDLE);
  assign c = zf ? '0 : tab_rdata;
  assign cfg_ok = (cfg.site_count != '0) && (cfg.site_count <= LIM_N) &&
                  (cfg.set_bit_count <= cfg.site_count);
  assign lo_mask = WORD_W'((64'h1 << cfg.site_count) - 64'h1);
  assign fill_row_end = (fk == fn);
  assign fill_end = fill_row_end && (fn == LIM_N);
  assign pm1 = p - REG_W'(1);
  assign take = (p < i) || (c <= rem);
  assign inx = take ? i - REG_W'(1) : i;
  assign bitp = WORD_W'(1) << p[4:0];
  assign sum_fin = pend ? sum + c : sum;

  always_comb begin
    state_next  = state;
    fn_next     = fn;
    fk_next     = fk;
    held_next   = held;
    p_next      = p;
    i_next      = i;
    cnt_next    = cnt;
    rem_next    = rem;
    pat_next    = pat;
    sum_next    = sum;
    val_next    = val;
    cmd_next    = cmd;
    zf_next     = zf;
    pend_next   = pend;
    done_next   = 1'b0;
    error_next  = error;
    result_next = result;
    tab_we      = 1'b0;
    tab_waddr   = '0;
    tab_wdata   = '0;
    tab_raddr   = '0;

    unique case (state)
      // fill reads row n-1 and writes row n, so the two ports never meet
      S_FILL_RD: begin
        if (fk == '0 || fill_row_end) begin
          tab_we     = 1'b1;
          tab_waddr  = tab_addr(fn, fk);
          tab_wdata  = WORD_W'(1);
          held_next  = WORD_W'(1);
          fn_next    = fill_row_end ? fn + REG_W'(1) : fn;
          fk_next    = fill_row_end ? '0 : fk + REG_W'(1);
          state_next = fill_end ? S_IDLE : S_FILL_RD;
        end else begin
          tab_raddr  = tab_addr(fn - REG_W'(1), fk);
          state_next = S_FILL_WR;
        end
      end
      S_FILL_WR: begin
        tab_we     = 1'b1;
        tab_waddr  = tab_addr(fn, fk);
        tab_wdata  = held + tab_rdata;
        held_next  = tab_rdata;
        fn_next    = fill_row_end ? fn + REG_W'(1) : fn;
        fk_next    = fill_row_end ? '0 : fk + REG_W'(1);
        state_next = fill_end ? S_IDLE : S_FILL_RD;
      end
      S_IDLE: begin
        if (start) begin
          cmd_next = command;
          val_next = value;
          if (!cfg_ok || (command == CMD_RANK && (value & ~lo_mask) != '0)) begin
            done_next   = 1'b1;
            error_next  = 1'b1;
            result_next = '0;
          end else if (command == CMD_UNRANK) begin
            tab_raddr  = tab_addr(cfg.site_count, cfg.set_bit_count);
            zf_next    = 1'b0;
            state_next = S_UCHK;
          end else begin
            p_next     = cfg.site_count - REG_W'(1);
            i_next     = cfg.set_bit_count;
            cnt_next   = '0;
            sum_next   = '0;
            pend_next  = 1'b0;
            state_next = S_RWALK;
          end
        end
      end
      S_UCHK: begin
        if (val >= tab_rdata) begin
          done_next   = 1'b1;
          error_next  = 1'b1;
          result_next = '0;
          state_next  = S_IDLE;
        end else if (cfg.set_bit_count == '0) begin
          done_next   = 1'b1;
          error_next  = 1'b0;
          result_next = '0;
          state_next  = S_IDLE;
        end else begin
          rem_next   = val;
          pat_next   = '0;
          p_next     = cfg.site_count - REG_W'(1);
          i_next     = cfg.set_bit_count;
          tab_raddr  = tab_addr(cfg.site_count - REG_W'(1), cfg.set_bit_count);
          zf_next    = cfg.set_bit_count > cfg.site_count - REG_W'(1);
          state_next = S_UWALK;
        end
      end
      // one position per cycle: the compare picks the next table address
      S_UWALK: begin
        p_next    = pm1;
        i_next    = inx;
        tab_raddr = tab_addr(pm1, inx);
        zf_next   = inx > pm1;
        if (take) begin
          rem_next = rem - c;
          pat_next = pat | bitp;
          if (i == REG_W'(1)) begin
            done_next   = 1'b1;
            error_next  = 1'b0;
            result_next = pat | bitp;
            state_next  = S_IDLE;
          end
        end
      end
      S_RWALK: begin
        sum_next  = sum_fin;
        pend_next = val[p[4:0]];
        if (val[p[4:0]]) begin
          tab_raddr = tab_addr(p, i);
          zf_next   = i > p;
          i_next    = i - REG_W'(1);
          cnt_next  = cnt + REG_W'(1);
        end
        if (p == '0) begin
          state_next = S_RLAST;
        end else begin
          p_next = pm1;
        end
      end
      S_RLAST: begin
        done_next = 1'b1;
        if (cnt != cfg.set_bit_count) begin
          error_next  = 1'b1;
          result_next = '0;
        end else begin
          error_next  = 1'b0;
          result_next = sum_fin;
        end
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL_RD;
      fn    <= '0;
      fk    <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fn    <= fn_next;
      fk    <= fk_next;
      done  <= done_next;
    end
    held   <= held_next;
    p      <= p_next;
    i      <= i_next;
    cnt    <= cnt_next;
    rem    <= rem_next;
    pat    <= pat_next;
    sum    <= sum_next;
    val    <= val_next;
    cmd    <= cmd_next;
    zf     <= zf_next;
    pend   <= pend_next;
    error  <= error_next;
    result <= result_next;
  end

  `CRU_ASSERT_IMP(a_err_zero, done && error, result == '0)
  `CRU_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)
  `CRU_ASSERT_IMP(a_no_done_fill, state == S_FILL_RD || state == S_FILL_WR, !done)
  `CRU_ASSERT_IMP(a_uwalk_bits_left, state == S_UWALK, i != '0)
  `CRU_ASSERT_IMP(a_unrank_pop, done && !error && cmd == CMD_UNRANK,
                  $countones(result) == int'(cfg.set_bit_count))

endmodule

// ===== sv/combination_rank_unrank.sv =====
// Top level: configuration registers, binomial table RAM and the rank/unrank sequencer.
//
//  channel   handshake            payload
//  command   start / busy         command, value
//  result    done (strobe)        result, error
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Unrank walks down the sites until its last set bit is placed, rank walks every site;
// each walk step is at most one read of the binomial table RAM.
// After reset the table is built row by row, rows 0 to L with L = min(MAX_SITES, 32);
// busy stays high until then.
// A bad configuration or out-of-range rank pattern is answered from idle with no walk.
// Results show for one cycle on done; the receiver cannot stall them.
`timescale 1ns / 1ps
module combination_rank_unrank import ccr_pkg::*; #(
  parameter int MAX_SITES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              command,
  input  logic [WORD_W-1:0] value,
  output logic              done,
  output logic [WORD_W-1:0] result,
  output logic              error,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [REG_W-1:0]  cfg_data
);

  localparam int DEPTH = tab_depth(MAX_SITES);
  localparam int AW = $clog2(DEPTH);

  cfg_t              cfg;
  logic              tab_we;
  logic [AW-1:0]     tab_waddr, tab_raddr;
  logic [WORD_W-1:0] tab_wdata, tab_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.site_count    <= REG_W'(32);
      cfg.set_bit_count <= REG_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SITE_COUNT:    cfg.site_count    <= cfg_data;
        REG_SET_BIT_COUNT: cfg.set_bit_count <= cfg_data;
        default: ;
      endcase
    end
  end

  ccr_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_tab (
    .clk  (clk),
    .we   (tab_we),
    .waddr(tab_waddr),
    .wdata(tab_wdata),
    .raddr(tab_raddr),
    .rdata(tab_rdata)
  );

  ccr_seq #(
    .MAX_SITES(MAX_SITES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .start    (start),
    .command  (command),
    .value    (value),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .error    (error),
    .tab_we   (tab_we),
    .tab_waddr(tab_waddr),
    .tab_wdata(tab_wdata),
    .tab_raddr(tab_raddr),
    .tab_rdata(tab_rdata)
  );

endmodule

// ===== bench/combination_rank_unrank_checker.sv =====
// Checker for combination_rank_unrank: predicts each conversion and compares the result beats.
`timescale 1ns / 1ps
module combination_rank_unrank_checker import ccr_pkg::*; #(
  parameter int MAX_SITES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic              command,
  input  logic [WORD_W-1:0] value,
  input  logic              done,
  input  logic [WORD_W-1:0] result,
  input  logic              error,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [REG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending
);

  typedef struct {
    logic [WORD_W-1:0] result;
    logic              error;
  } conversion_t;

  localparam int SITE_LIMIT = (MAX_SITES < WORD_W) ? MAX_SITES : WORD_W;

  longint unsigned pascal [0:63][0:63];
  int              site_count_q;
  int              set_bit_count_q;
  int              mismatches;
  conversion_t     expected_conversions[$];

  initial begin
    for (int n = 0; n < 64; n++) begin
      for (int k = 0; k < 64; k++) pascal[n][k] = 0;
      pascal[n][0] = 1;
      for (int k = 1; k <= n; k++) pascal[n][k] = pascal[n-1][k-1] + pascal[n-1][k];
    end
  end

  function automatic conversion_t convert(input logic cmd, input logic [WORD_W-1:0] val);
    conversion_t     c;
    int              sites;
    int              ones;
    int              p;
    int              i;
    longint unsigned rem;
    longint unsigned acc;
    sites = site_count_q;
    ones = set_bit_count_q;
    c.result = '0;
    c.error = 1'b1;
    if (sites < 1 || sites > SITE_LIMIT || ones > sites) return c;
    if (cmd == CMD_UNRANK) begin
      if (val >= pascal[sites][ones]) return c;
      rem = val;
      // each set bit goes to the highest position whose binomial still fits
      for (i = ones; i >= 1; i--) begin
        p = sites - 1;
        while (p > i - 1 && pascal[p][i] > rem) p--;
        rem -= pascal[p][i];
        c.result[p] = 1'b1;
      end
    end else begin
      if (sites < WORD_W && (val >> sites) != 0) return c;
      if ($countones(val) != ones) return c;
      acc = 0;
      i = ones;
      for (p = sites; p > 0; p--) begin
        if (val[p-1]) begin
          acc += pascal[p-1][i];
          i--;
        end
      end
      c.result = acc[WORD_W-1:0];
    end
    c.error = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin : watch
    conversion_t want;
    if (rst) begin
      site_count_q = 32;
      set_bit_count_q = 16;
      expected_conversions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SITE_COUNT) site_count_q = cfg_data;
        else set_bit_count_q = cfg_data;
      end
      if (done) begin
        if (expected_conversions.size() == 0) begin
          $error("result beat with no conversion pending: result %h error %b", result, error);
          mismatches++;
        end else begin
          want = expected_conversions.pop_front();
          if (result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, result);
            mismatches++;
          end
          if (error !== want.error) begin
            $error("error: expected %b, actual %b", want.error, error);
            mismatches++;
          end
        end
      end
      if (start && !busy) expected_conversions.push_back(convert(command, value));
    end
    pending <= expected_conversions.size();
    fail_count <= mismatches;
  end

endmodule

// ===== bench/tb_combination_rank_unrank.sv =====
// Testbench top for combination_rank_unrank: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps
module tb_combination_rank_unrank import ccr_pkg::*; ();

  localparam int ITEM_TARGET = 550;
  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              command;
  logic [WORD_W-1:0] value;
  logic              done;
  logic [WORD_W-1:0] result;
  logic              error;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_index;
  logic [REG_W-1:0]  cfg_data;
  int                fail_count;
  int                pending;
  int                cycle_count;
  int                items_sent;
  bit                no_gaps;
  int                sites;
  int                ones;

  combination_rank_unrank u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .value     (value),
    .done      (done),
    .result    (result),
    .error     (error),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  combination_rank_unrank_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .value      (value),
    .done       (done),
    .result     (result),
    .error      (error),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint unsigned combo_count(input int n, input int k);
    longint unsigned c;
    c = 1;
    for (int j = 0; j < k; j++) c = c * longint'(n - j) / longint'(j + 1);
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] random_pattern(input int n, input int k);
    logic [WORD_W-1:0] pat;
    int                cnt;
    int                b;
    pat = '0;
    cnt = 0;
    while (cnt < k) begin
      b = $urandom_range(0, n - 1);
      if (!pat[b]) begin
        pat[b] = 1'b1;
        cnt++;
      end
    end
    return pat;
  endfunction

  // start stays high across back-to-back beats; lowered only for a gap
  task automatic send(input logic cmd, input logic [WORD_W-1:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    value <= val;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  task automatic set_config(input logic [REG_W-1:0] n, input logic [REG_W-1:0] k);
    start <= 1'b0;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_SITE_COUNT;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_SET_BIT_COUNT;
    cfg_data <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sites = n;
    ones = k;
  endtask

  task automatic send_random_item();
    longint unsigned total;
    logic [WORD_W-1:0] pat;
    total = combo_count(sites, ones);
    case ($urandom_range(0, 9))
      0, 1, 2: send(CMD_UNRANK, WORD_W'($urandom % total));
      3: send(CMD_UNRANK, ($urandom_range(0, 1) != 0) ? WORD_W'(total - 1) : '0);
      4, 5, 6, 7: send(CMD_RANK, random_pattern(sites, ones));
      8: send(logic'($urandom_range(0, 1)), $urandom);
      default: begin
        if ($urandom_range(0, 1) != 0) begin
          send(CMD_UNRANK, WORD_W'(total + $urandom_range(0, 3)));
        end else begin
          pat = random_pattern(sites, ones);
          pat[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
          send(CMD_RANK, pat);
        end
      end
    endcase
  endtask

  initial begin
    int phase_items;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_UNRANK;
    value = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SITE_COUNT;
    cfg_data = '0;
    items_sent = 0;
    no_gaps = 1'b0;
    sites = 32;
    ones = 16;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset configuration: 32 sites, 16 ones
    send(CMD_UNRANK, '0);
    send(CMD_UNRANK, 32'd601080389);
    send(CMD_UNRANK, 32'd601080390);
    send(CMD_UNRANK, 32'hFFFF_FFFF);
    send(CMD_RANK, 32'hFFFF_0000);
    send(CMD_RANK, 32'hAAAA_AAAA);
    send(CMD_RANK, 32'hFFFF_FFFF);
    // no set bits
    set_config(6'd32, 6'd0);
    send(CMD_UNRANK, '0);
    send(CMD_RANK, '0);
    send(CMD_UNRANK, 32'd1);
    set_config(6'd32, 6'd32);
    send(CMD_UNRANK, '0);
    send(CMD_RANK, 32'hFFFF_FFFF);
    set_config(6'd1, 6'd1);
    send(CMD_UNRANK, '0);
    send(CMD_RANK, 32'd1);
    send(CMD_RANK, 32'd3);
    // a one above the site count
    set_config(6'd31, 6'd15);
    send(CMD_RANK, 32'h8000_3FFF);
    send(CMD_UNRANK, '0);
    // bad configurations
    set_config(6'd0, 6'd0);
    send(CMD_UNRANK, '0);
    send(CMD_RANK, '0);
    set_config(6'd63, 6'd63);
    send(CMD_RANK, 32'hFFFF_FFFF);
    set_config(6'd10, 6'd11);
    send(CMD_UNRANK, '0);
    set_config(6'd33, 6'd1);
    send(CMD_RANK, 32'd1);

    while (items_sent < ITEM_TARGET) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_items = $urandom_range(20, 50);
      case ($urandom_range(0, 11))
        0: begin
          case ($urandom_range(0, 4))
            0: set_config(6'd32, 6'd0);
            1: set_config(6'd32, 6'd1);
            2: set_config(6'd32, 6'd16);
            3: set_config(6'd32, 6'd31);
            default: set_config(6'd32, 6'd32);
          endcase
        end
        1: set_config(6'd1, REG_W'($urandom_range(0, 1)));
        2: begin
          set_config(($urandom_range(0, 1) != 0) ? 6'd0 : REG_W'($urandom_range(33, 63)),
                     REG_W'($urandom_range(0, 63)));
          phase_items = 6;
        end
        3: begin
          sites = $urandom_range(1, 31);
          set_config(REG_W'(sites), REG_W'($urandom_range(sites + 1, 63)));
          phase_items = 6;
        end
        default: begin
          sites = $urandom_range(1, 32);
          set_config(REG_W'(sites), REG_W'($urandom_range(0, sites)));
        end
      endcase
      if (sites < 1 || sites > 32 || ones > sites) begin
        repeat (phase_items) send(logic'($urandom_range(0, 1)), $urandom);
      end else begin
        repeat (phase_items) send_random_item();
      end
    end

    start <= 1'b0;
    wait_idle();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
